### rtl/core/smoothed_level_bar_graph_driver_assert.svh
// assertion macros for the smoothed level bar graph driver
// expects a clock named clk and an active-high reset named rst in scope
`ifndef SMOOTHED_LEVEL_BAR_GRAPH_DRIVER_ASSERT_SVH
`define SMOOTHED_LEVEL_BAR_GRAPH_DRIVER_ASSERT_SVH

// same-cycle implication
`define SLBG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLBG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/slbg_pkg.sv
// shared types and constants for the smoothed level bar graph driver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package slbg_pkg;
  localparam int NUM_PIXELS_DEF = 9;
  localparam int IDX_W = 4;
  localparam int HUE_W = 10;
  localparam int LVL_W = 8;
  localparam int SAMPLE_W = 16;
  localparam int ACC_W = 25;
  localparam int DIV_W = 12;
  localparam int CNT_W = 5;
  localparam int K_W = 5;
  localparam int MPL_W = 10;

  localparam logic [2:0] REG_LEVEL_MIN = 3'd0;
  localparam logic [2:0] REG_LEVEL_MAX = 3'd1;
  localparam logic [2:0] REG_SMOOTH = 3'd2;
  localparam logic [2:0] REG_UPP = 3'd3;
  localparam logic [2:0] REG_HUE_MIN = 3'd4;
  localparam logic [2:0] REG_HUE_MAX = 3'd5;
  localparam logic [2:0] REG_FLASH = 3'd6;

  // one bar graph frame handed to the pixel emitter
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [K_W-1:0]   k;       // last full pixel, saturated
    logic [LVL_W-1:0] partial;
    logic             dark;    // all pixels off
  } frame_t;
endpackage
`default_nettype wire

### rtl/core/smoothed_level_bar_graph_driver.sv
// smoothed level bar graph driver, top level
// an in-range sample runs through a multiply, a divide, a multiply and three divides,
// one bit per cycle, plus sequencing (the second multiply and divide are skipped when
// level_max is not above level_min), then its pixels go out one pixel per cycle while
// the output is not stalled; the next sample is taken only once the sequencer is idle,
// and a flash tick is handed straight to the emitter; rst is synchronous
// and restores register defaults, level 450 and the flash state off
`timescale 1ns / 1ps
`default_nettype none
module smoothed_level_bar_graph_driver #(
  parameter int NUM_PIXELS = slbg_pkg::NUM_PIXELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // sample_level
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // pixel_index, pixel_hue, pixel_level
  output logic             m_axis_tlast,  // last_pixel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL1 = 4'd1;
  localparam logic [3:0] ST_DIV1 = 4'd2;
  localparam logic [3:0] ST_HUE = 4'd3;
  localparam logic [3:0] ST_MUL2 = 4'd4;
  localparam logic [3:0] ST_DIV2 = 4'd5;
  localparam logic [3:0] ST_KSTART = 4'd6;
  localparam logic [3:0] ST_KDIV = 4'd7;
  localparam logic [3:0] ST_PDIV = 4'd8;
  localparam logic [3:0] ST_EMIT = 4'd9;

  logic [11:0] level_min, level_max, upp;
  logic [7:0]  smooth;
  logic [9:0]  hue_min, hue_max;
  logic [15:0] flash_ticks;

  logic [3:0]  state, state_next;
  logic [15:0] level, lv;
  logic        flashing, flash_lit;
  logic [15:0] flash_count;
  slbg_pkg::frame_t frame;
  logic [9:0]  hue_r;
  logic        hue_neg;

  logic        mul_start, mul_done;
  logic [15:0] mul_mcand;
  logic [9:0]  mul_mplier;
  logic [24:0] mul_addend, mul_prod;
  logic        div_start, div_busy, div_done;
  logic [24:0] div_dvd, div_quot;
  logic [11:0] div_dsr, div_rem;
  logic [4:0]  div_steps;
  logic        emit_start, emit_ready;

  logic [15:0] s;
  logic        in_xfer;
  logic [7:0]  f_eff;
  logic [11:0] upp_eff;
  logic [15:0] ft_eff;
  logic [11:0] lv_clamp, span;
  logic [15:0] kdiff;
  logic [19:0] r255;
  logic        lit_now;
  logic [15:0] cnt_inc;

  assign s = s_axis_tdata;
  assign s_axis_tready = state == ST_IDLE;
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign f_eff = (smooth == 8'd0) ? 8'd1 : smooth;
  assign upp_eff = (upp == 12'd0) ? 12'd1 : upp;
  assign ft_eff = (flash_ticks == 16'd0) ? 16'd1 : flash_ticks;
  assign span = level_max - level_min;
  assign lv_clamp = (lv < {4'd0, level_min}) ? level_min :
                    (lv > {4'd0, level_max}) ? level_max : lv[11:0];
  assign kdiff = (lv >= {4'd0, level_min}) ? lv - {4'd0, level_min} : 16'd0;
  assign r255 = {div_rem, 8'd0} - {8'd0, div_rem};
  assign lit_now = flashing ? flash_lit : 1'b1;
  assign cnt_inc = (flashing ? flash_count : 16'd0) + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_min <= 12'd450;
      level_max <= 12'd2000;
      smooth <= 8'd100;
      upp <= 12'd172;
      hue_min <= 10'd307;
      hue_max <= 10'd0;
      flash_ticks <= 16'd33;
    end else if (cfg_valid) begin
      case (cfg_index)
        slbg_pkg::REG_LEVEL_MIN: level_min <= cfg_data[11:0];
        slbg_pkg::REG_LEVEL_MAX: level_max <= cfg_data[11:0];
        slbg_pkg::REG_SMOOTH:    smooth <= cfg_data[7:0];
        slbg_pkg::REG_UPP:       upp <= cfg_data[11:0];
        slbg_pkg::REG_HUE_MIN:   hue_min <= cfg_data[9:0];
        slbg_pkg::REG_HUE_MAX:   hue_max <= cfg_data[9:0];
        slbg_pkg::REG_FLASH:     flash_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: operands for the serial units are issued on the cycle a state is left
  always_comb begin
    state_next = state;
    mul_start = 1'b0;
    mul_mcand = level;
    mul_mplier = {2'b00, f_eff - 8'd1};
    mul_addend = {9'd0, s};
    div_start = 1'b0;
    div_dvd = mul_prod;
    div_dsr = {4'd0, f_eff};
    div_steps = 5'd25;
    emit_start = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_xfer && !(flashing && s <= {4'd0, level_max})) begin
          if (s > {4'd0, level_max}) begin
            state_next = ST_EMIT;
          end else if (s > {4'd0, level_min} && s != level) begin
            mul_start = 1'b1;
            state_next = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_next = ST_DIV1;
        end
      end
      ST_DIV1: if (div_done) state_next = ST_HUE;
      ST_HUE: begin
        if (level_max <= level_min) begin
          state_next = ST_KSTART;
        end else begin
          mul_start = 1'b1;
          mul_mcand = {4'd0, lv_clamp - level_min};
          mul_mplier = hue_neg ? hue_min - hue_max : hue_max - hue_min;
          mul_addend = {14'd0, span[11:1]};
          state_next = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_dvd = {mul_prod[22:0], 2'b00};
          div_dsr = span;
          div_steps = 5'd23;
          state_next = ST_DIV2;
        end
      end
      ST_DIV2: if (div_done) state_next = ST_KSTART;
      ST_KSTART: begin
        div_start = 1'b1;
        div_dvd = {kdiff, 9'd0};
        div_dsr = upp_eff;
        div_steps = 5'd16;
        state_next = ST_KDIV;
      end
      ST_KDIV: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd = {r255, 5'd0};
          div_dsr = upp_eff;
          div_steps = 5'd20;
          state_next = ST_PDIV;
        end
      end
      ST_PDIV: if (div_done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_ready) begin
          emit_start = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      level <= 16'd450;
      flashing <= 1'b0;
      flash_lit <= 1'b0;
      flash_count <= 16'd0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (flashing && s <= {4'd0, level_max}) begin
              flashing <= 1'b0;
              flash_lit <= 1'b0;
              flash_count <= 16'd0;
              level <= s;
            end else if (s > {4'd0, level_max}) begin
              flashing <= 1'b1;
              frame.hue <= lit_now ? hue_max : 10'd0;
              frame.k <= 5'd16;
              frame.partial <= 8'd0;
              frame.dark <= !lit_now;
              if (cnt_inc >= ft_eff) begin
                flash_lit <= !lit_now;
                flash_count <= 16'd0;
              end else begin
                flash_lit <= lit_now;
                flash_count <= cnt_inc;
              end
            end
          end
          hue_neg <= hue_max < hue_min;
        end
        ST_DIV1: begin
          if (div_done) begin
            lv <= div_quot[15:0];
            level <= div_quot[15:0];
            hue_r <= hue_min;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            hue_r <= hue_neg ? hue_min - div_quot[9:0] : hue_min + div_quot[9:0];
          end
        end
        ST_KDIV: begin
          if (div_done) frame.k <= (div_quot[15:0] > 16'd16) ? 5'd16 : div_quot[4:0];
        end
        ST_PDIV: begin
          if (div_done) begin
            frame.partial <= div_quot[7:0];
            frame.hue <= hue_r;
            frame.dark <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  slbg_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .mcand(mul_mcand), .mplier(mul_mplier),
    .addend(mul_addend), .done(mul_done), .prod(mul_prod)
  );

  slbg_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd), .divisor(div_dsr),
    .steps(div_steps), .busy(div_busy), .done(div_done), .quot(div_quot), .rem(div_rem)
  );

  slbg_emit #(.NUM_PIXELS(NUM_PIXELS)) u_emit (
    .clk(clk), .rst(rst), .start(emit_start), .frame(frame), .ready(emit_ready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

`include "smoothed_level_bar_graph_driver_assert.svh"

  `SLBG_ASSERT_IMP(a_div_free, div_start, !div_busy, "divider started while busy")
  `SLBG_ASSERT_IMP(a_emit_free, emit_start, emit_ready, "emitter started while busy")
  `SLBG_ASSERT_IMP(a_last_idx, m_axis_tvalid && m_axis_tlast, m_axis_tdata[3:0] == 4'(NUM_PIXELS - 1), "last pixel index mismatch")
  `SLBG_ASSERT_NXT(a_emit_idle, emit_start, state == ST_IDLE, "sequencer not idle after frame handoff")

endmodule
`default_nettype wire

### rtl/core/slbg_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on slbg_pkg
`timescale 1ns / 1ps
`default_nettype none
module slbg_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [slbg_pkg::ACC_W-1:0]     dividend, // left aligned
  input  wire logic [slbg_pkg::DIV_W-1:0]     divisor,
  input  wire logic [slbg_pkg::CNT_W-1:0]     steps,
  output logic                                busy,
  output logic                                done,
  output logic [slbg_pkg::ACC_W-1:0]          quot,
  output logic [slbg_pkg::DIV_W-1:0]          rem
);
  logic [slbg_pkg::ACC_W-1:0] dvd;
  logic [slbg_pkg::DIV_W-1:0] dsr;
  logic [slbg_pkg::CNT_W-1:0] cnt;
  logic [slbg_pkg::DIV_W:0]   trial;
  logic                       ge;

  assign trial = {rem, dvd[slbg_pkg::ACC_W-1]};
  assign ge = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt <= steps;
        dvd <= dividend;
        dsr <= divisor;
        rem <= '0;
        quot <= '0;
      end else if (busy) begin
        rem <= ge ? slbg_pkg::DIV_W'(trial - {1'b0, dsr}) : trial[slbg_pkg::DIV_W-1:0];
        quot <= {quot[slbg_pkg::ACC_W-2:0], ge};
        dvd <= {dvd[slbg_pkg::ACC_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == slbg_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/slbg_mul.sv
// shift-add multiplier, one multiplier bit per cycle, accumulator preloaded
// depends on slbg_pkg
`timescale 1ns / 1ps
`default_nettype none
module slbg_mul (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [15:0]                 mcand,
  input  wire logic [slbg_pkg::MPL_W-1:0]  mplier,
  input  wire logic [slbg_pkg::ACC_W-1:0]  addend,
  output logic                             done,
  output logic [slbg_pkg::ACC_W-1:0]       prod
);
  logic                          busy;
  logic [3:0]                    cnt;
  logic [slbg_pkg::ACC_W-1:0]    mc;
  logic [slbg_pkg::MPL_W-1:0]    mp;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt <= 4'(slbg_pkg::MPL_W);
        mc <= slbg_pkg::ACC_W'(mcand);
        mp <= mplier;
        prod <= addend;
      end else if (busy) begin
        if (mp[0]) prod <= prod + mc;
        mc <= {mc[slbg_pkg::ACC_W-2:0], 1'b0};
        mp <= {1'b0, mp[slbg_pkg::MPL_W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/slbg_emit.sv
// pixel emitter: walks the strip one pixel per transfer behind an output register
// depends on slbg_pkg
`timescale 1ns / 1ps
`default_nettype none
module slbg_emit #(
  parameter int NUM_PIXELS = slbg_pkg::NUM_PIXELS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire slbg_pkg::frame_t    frame,
  output logic                     ready,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [23:0]              m_axis_tdata, // pixel_index, pixel_hue, pixel_level
  output logic                     m_axis_tlast
);
  localparam logic [slbg_pkg::IDX_W-1:0] LAST_IDX = slbg_pkg::IDX_W'(NUM_PIXELS - 1);

  logic                           busy;
  logic [slbg_pkg::IDX_W-1:0]     idx;
  slbg_pkg::frame_t               fr;
  logic                           adv;
  logic [slbg_pkg::K_W-1:0]       pos;
  logic [slbg_pkg::HUE_W-1:0]     hue_next;
  logic [slbg_pkg::LVL_W-1:0]     lvl_next;

  assign ready = !busy;
  assign adv = busy && (!m_axis_tvalid || m_axis_tready);
  assign pos = slbg_pkg::K_W'(idx);

  always_comb begin
    hue_next = '0;
    lvl_next = '0;
    if (!fr.dark) begin
      if (pos <= fr.k) begin
        hue_next = fr.hue;
        lvl_next = '1;
      end else if (pos == fr.k + 1'b1) begin
        hue_next = fr.hue;
        lvl_next = fr.partial;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        idx <= '0;
        fr <= frame;
      end else if (adv) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {2'b00, lvl_next, hue_next, idx};
        m_axis_tlast <= idx == LAST_IDX;
        if (idx == LAST_IDX) busy <= 1'b0;
        idx <= idx + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire
